>>> hdl/byte_substring_search_top_defines.svh
// assertion macros used by the checker file
`ifndef BYTE_SUBSTRING_SEARCH_TOP_DEFINES_SVH
`define BYTE_SUBSTRING_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define BSS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("search block check failed");

// next-cycle implication, sampled on clk, quiet in reset
`define BSS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("search block check failed");

`endif

>>> hdl/bss_pkg.sv
// shared constants and types of the byte substring search block
package bss_pkg;

    localparam int MAX_NEEDLE_DEF = 8;
    localparam int POS_BITS_DEF   = 16;

    localparam int NEEDLE_W = 64;
    localparam int LEN_W    = 4;
    localparam int OFFSET_W = 16;
    localparam int CFG_W    = 64;
    localparam int ADDR_W   = 2;

    localparam logic [ADDR_W-1:0] REG_NEEDLE_BYTES   = 2'd0;
    localparam logic [ADDR_W-1:0] REG_NEEDLE_LENGTH  = 2'd1;
    localparam logic [ADDR_W-1:0] REG_START_OFFSET   = 2'd2;
    localparam logic [ADDR_W-1:0] REG_SEARCH_REVERSE = 2'd3;

    typedef struct packed {
        logic [NEEDLE_W-1:0] needle_bytes;
        logic [LEN_W-1:0]    needle_length;
        logic [OFFSET_W-1:0] start_offset;
        logic                search_reverse;
    } cfg_t;

    typedef struct packed {
        logic step;
        logic last;
    } step_t;

endpackage

>>> hdl/bss_match.sv
// compares the newest window bytes against the needle for every length
module bss_match #(
    parameter int MAX_NEEDLE = bss_pkg::MAX_NEEDLE_DEF
) (
    input  logic [8*MAX_NEEDLE-1:0]       window,
    input  logic [bss_pkg::NEEDLE_W-1:0]  needle,
    input  logic [bss_pkg::LEN_W-1:0]     len,
    output logic                          match
);

    logic [MAX_NEEDLE:1] eq;

    genvar gl, gi;
    generate
        for (gl = 1; gl <= MAX_NEEDLE; gl++)
        begin : g_len
            logic [8*gl-1:0] expv;
            // needle byte 0 is the oldest byte of the window
            for (gi = 0; gi < gl; gi++)
            begin : g_byte
                assign expv[8*(gl-1-gi) +: 8] = needle[8*gi +: 8];
            end
            assign eq[gl] = (window[8*gl-1:0] == expv);
        end
    endgenerate

    always_comb
    begin
        match = 1'b0;
        for (int l = 1; l <= MAX_NEEDLE; l++)
        begin
            if (len == bss_pkg::LEN_W'(l) && eq[l])
            begin
                match = 1'b1;
            end
        end
    end

endmodule

>>> hdl/bss_tracker.sv
// stream state: window, byte count and the chosen match start
module bss_tracker #(
    parameter int MAX_NEEDLE = bss_pkg::MAX_NEEDLE_DEF,
    parameter int POS_BITS   = bss_pkg::POS_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bss_pkg::cfg_t       cfg,
    input  bss_pkg::step_t      ctl,
    input  logic [7:0]          hay_byte,
    output logic [POS_BITS-1:0] res_position,
    output logic                res_found,
    output logic                res_overflow
);

    localparam int WIN_W = 8 * MAX_NEEDLE;
    localparam int CNT_W = POS_BITS + 1;
    localparam int CMP_W = ((POS_BITS > bss_pkg::OFFSET_W) ? POS_BITS : bss_pkg::OFFSET_W) + 1;
    localparam logic [bss_pkg::LEN_W-1:0] LEN_MAX = bss_pkg::LEN_W'(MAX_NEEDLE);

    logic [WIN_W-1:0]    window_reg, window_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                have_reg, have_next;
    logic [POS_BITS-1:0] best_reg, best_next;

    logic [CNT_W-1:0]    count_inc;
    logic [CNT_W-1:0]    pos_full;
    logic [CMP_W-1:0]    pos_cmp, start_cmp;
    logic                len_ok;
    logic                match;
    logic                take;

    generate
        if (MAX_NEEDLE > 1)
        begin : g_shift
            assign window_next = {window_reg[WIN_W-9:0], hay_byte};
        end
        else
        begin : g_single
            assign window_next = hay_byte;
        end
    endgenerate

    bss_match #(
        .MAX_NEEDLE(MAX_NEEDLE)
    ) u_match (
        .window (window_next),
        .needle (cfg.needle_bytes),
        .len    (cfg.needle_length),
        .match  (match)
    );

    always_comb
    begin
        count_inc = count_reg + CNT_W'(1);
        len_ok    = (cfg.needle_length != '0) && (cfg.needle_length <= LEN_MAX)
                    && (count_inc >= CNT_W'(cfg.needle_length));
        pos_full  = count_inc - CNT_W'(cfg.needle_length);
        pos_cmp   = CMP_W'(pos_full[POS_BITS-1:0]);
        start_cmp = CMP_W'(cfg.start_offset);

        // counting stops once the top bit is set
        take = 1'b0;
        if (!count_reg[POS_BITS] && len_ok && match)
        begin
            if (cfg.search_reverse)
            begin
                take = (pos_cmp <= start_cmp);
            end
            else
            begin
                take = !have_reg && (pos_cmp >= start_cmp);
            end
        end

        count_next = count_reg[POS_BITS] ? count_reg : count_inc;
        have_next  = have_reg || take;
        best_next  = take ? pos_full[POS_BITS-1:0] : best_reg;

        res_found    = have_next;
        res_overflow = count_next[POS_BITS];
        if (have_next)
        begin
            res_position = best_next;
        end
        else if (count_next[POS_BITS])
        begin
            res_position = '1;
        end
        else
        begin
            res_position = count_next[POS_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            have_reg   <= 1'b0;
            best_reg   <= '0;
        end
        else if (ctl.step)
        begin
            if (ctl.last)
            begin
                window_reg <= '0;
                count_reg  <= '0;
                have_reg   <= 1'b0;
                best_reg   <= '0;
            end
            else
            begin
                window_reg <= window_next;
                count_reg  <= count_next;
                have_reg   <= have_next;
                best_reg   <= best_next;
            end
        end
    end

endmodule

>>> hdl/byte_substring_search_top.sv
// top level of the streaming byte substring search
//
// channel | dir | handshake          | contents
// s_axis  | in  | s_tvalid/s_tready  | tdata = hay_byte, tlast = last_byte
// m_axis  | out | m_tvalid/m_tready  | tdata = match_position, tuser = found, overflow
// cfg     | in  | cfg_we             | cfg_addr selects register, cfg_wdata value
//
// one byte per cycle sustained unless a last word waits behind a stalled result;
// the window compare and state update are combinational between the input register
// and state/result registers; m_tvalid rises once a haystack's last word advances.
// reset clears the stream state, the configuration and both valid flags.
// a stalled result blocks only a following last word; other bytes keep flowing.
module byte_substring_search_top #(
    parameter int MAX_NEEDLE = bss_pkg::MAX_NEEDLE_DEF,
    parameter int POS_BITS   = bss_pkg::POS_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // hay_byte
    input  logic                        s_tlast,   // last_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [((POS_BITS+7)/8)*8-1:0] m_tdata, // match_position
    output logic [1:0]                  m_tuser,   // found, overflow
    input  logic                        cfg_we,
    input  logic [bss_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [bss_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int TDATA_W = ((POS_BITS + 7) / 8) * 8;

    bss_pkg::cfg_t       cfg_reg;
    bss_pkg::step_t      ctl;

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;

    logic                out_valid_reg;
    logic [POS_BITS-1:0] out_pos_reg;
    logic                out_found_reg;
    logic                out_ovf_reg;

    logic                out_free;
    logic                advance;
    logic [POS_BITS-1:0] res_position;
    logic                res_found;
    logic                res_overflow;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign ctl.step = advance;
    assign ctl.last = in_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bss_pkg::REG_NEEDLE_BYTES:
                    cfg_reg.needle_bytes <= cfg_wdata;
                bss_pkg::REG_NEEDLE_LENGTH:
                    cfg_reg.needle_length <= cfg_wdata[bss_pkg::LEN_W-1:0];
                bss_pkg::REG_START_OFFSET:
                    cfg_reg.start_offset <= cfg_wdata[bss_pkg::OFFSET_W-1:0];
                bss_pkg::REG_SEARCH_REVERSE:
                    cfg_reg.search_reverse <= cfg_wdata[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    bss_tracker #(
        .MAX_NEEDLE(MAX_NEEDLE),
        .POS_BITS  (POS_BITS)
    ) u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .ctl          (ctl),
        .hay_byte     (in_byte_reg),
        .res_position (res_position),
        .res_found    (res_found),
        .res_overflow (res_overflow)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && in_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_pos_reg   <= res_position;
            out_found_reg <= res_found;
            out_ovf_reg   <= res_overflow;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_pos_reg);
    assign m_tuser  = {out_ovf_reg, out_found_reg};

endmodule

>>> hdl/bss_checker.sv
// port-level checks of the search block, bound to the top level
`include "byte_substring_search_top_defines.svh"

module bss_checker #(
    parameter int POS_BITS = bss_pkg::POS_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [((POS_BITS+7)/8)*8-1:0] m_tdata,
    input logic [1:0]                    m_tuser
);

    logic last_in_stalled;
    assign last_in_stalled = m_tvalid && !m_tready && s_tvalid && s_tready && s_tlast;

    // a result held by the sink stays offered
    `BSS_ASSERT_NXT(a_result_held, m_tvalid && !m_tready, m_tvalid)

    // a saturated length reads all ones when nothing was found
    `BSS_ASSERT_IMP(a_ovf_saturates, m_tvalid && m_tuser[1] && !m_tuser[0],
                    &m_tdata[POS_BITS-1:0])

    // a haystack always holds at least one byte
    `BSS_ASSERT_IMP(a_len_nonzero, m_tvalid && !m_tuser[1] && !m_tuser[0],
                    m_tdata[POS_BITS-1:0] != '0)

    // a second last word waits behind a stalled result
    `BSS_ASSERT_IMP(a_last_blocks, $past(last_in_stalled) && !m_tready, !s_tready)

endmodule

bind byte_substring_search_top bss_checker #(.POS_BITS(POS_BITS)) u_bss_checker (.*);

>>> tb/testbench.sv
// self-checking testbench for the streaming byte substring search block
`timescale 1ns / 100ps

module testbench;

    localparam int TDATA_W = ((bss_pkg::POS_BITS_DEF + 7) / 8) * 8;
    localparam logic [16:0] POS_LIMIT = 17'h10000;
    localparam int SETTLE_CYCLES = 8;

    typedef logic [7:0] byte_queue_t[$];

    typedef struct packed {
        logic [15:0] position;
        logic        found;
        logic        overflow;
    } search_result_t;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;   // hay_byte
    logic               s_tlast;   // last_byte
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;   // match_position
    logic [1:0]         m_tuser;   // found, overflow
    logic               cfg_we;
    logic [bss_pkg::ADDR_W-1:0] cfg_addr;
    logic [bss_pkg::CFG_W-1:0]  cfg_wdata;

    // configuration as the block should hold it
    logic [63:0] cfg_needle;
    logic [3:0]  cfg_len;
    logic [15:0] cfg_offset;
    logic        cfg_reverse;

    // stream state of the search
    logic [63:0] stream_window;
    logic [16:0] bytes_seen;
    logic        match_held;
    logic [15:0] match_start;

    search_result_t pending_results[$];
    int          fail_count;
    int          burst_left;
    bit          gaps_on;
    int          hold_request;
    ready_mode_t ready_mode;

    byte_substring_search_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // advance the search by one haystack word and queue the result on the last one
    task automatic predict_byte(input logic [7:0] hay_byte, input logic last_byte);
        logic [63:0]    pattern;
        logic [63:0]    mask;
        logic [16:0]    cand_pos;
        search_result_t res;
        int             len;
        len = cfg_len;
        stream_window = {stream_window[55:0], hay_byte};
        if (bytes_seen < POS_LIMIT)
        begin
            bytes_seen = bytes_seen + 17'd1;
            if (len != 0 && len <= bss_pkg::MAX_NEEDLE_DEF && bytes_seen >= len)
            begin
                cand_pos = bytes_seen - 17'(len);
                // oldest needle byte sits highest, like the window
                pattern = '0;
                for (int i = 0; i < len; i++)
                    pattern[8*(len-1-i) +: 8] = cfg_needle[8*i +: 8];
                mask = (len == 8) ? '1 : (64'd1 << (8 * len)) - 64'd1;
                if (((stream_window ^ pattern) & mask) == 64'd0)
                begin
                    if (cfg_reverse)
                    begin
                        if (cand_pos <= {1'b0, cfg_offset})
                        begin
                            match_held = 1'b1;
                            match_start = cand_pos[15:0];
                        end
                    end
                    else if (!match_held && cand_pos >= {1'b0, cfg_offset})
                    begin
                        match_held = 1'b1;
                        match_start = cand_pos[15:0];
                    end
                end
            end
        end
        if (last_byte)
        begin
            res.overflow = bytes_seen > 17'h0FFFF;
            res.found = match_held;
            res.position = match_held ? match_start
                         : (res.overflow ? 16'hFFFF : bytes_seen[15:0]);
            pending_results.push_back(res);
            stream_window = '0;
            bytes_seen = '0;
            match_held = 1'b0;
            match_start = '0;
        end
    endtask

    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = 0;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 6);
        end
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = value;
        s_tlast = last;
        do @(posedge clk); while (s_tready !== 1'b1);
        predict_byte(value, last);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic run_haystack(input byte_queue_t hay);
        foreach (hay[i])
            send_byte(hay[i], i == hay.size() - 1);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bss_pkg::ADDR_W-1:0] addr, input logic [63:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = addr;
        cfg_wdata = value;
        @(posedge clk);
        case (addr)
            bss_pkg::REG_NEEDLE_BYTES:   cfg_needle = value;
            bss_pkg::REG_NEEDLE_LENGTH:  cfg_len = value[3:0];
            bss_pkg::REG_START_OFFSET:   cfg_offset = value[15:0];
            bss_pkg::REG_SEARCH_REVERSE: cfg_reverse = value[0];
            default: ;
        endcase
    endtask

    // only called with the block idle
    task automatic set_config(input logic [63:0] needle, input logic [3:0] len,
                              input logic [15:0] offset, input logic reverse);
        wait_drained();
        write_reg(bss_pkg::REG_NEEDLE_BYTES, needle);
        write_reg(bss_pkg::REG_NEEDLE_LENGTH, {60'd0, len});
        write_reg(bss_pkg::REG_START_OFFSET, {48'd0, offset});
        write_reg(bss_pkg::REG_SEARCH_REVERSE, {63'd0, reverse});
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [7:0] hay_symbol();
        case ($urandom_range(0, 9))
            0:          return 8'($urandom);
            1, 2, 3, 4: return 8'h61;
            default:    return 8'h62;
        endcase
    endfunction

    task automatic test_empty_and_oversized_needle();
        byte_queue_t hay;
        // registers still at reset: empty needle
        hay = '{8'h61, 8'h62};
        run_haystack(hay);
        set_config(64'h6261, 4'd15, 16'd0, 1'b0);
        run_haystack(hay);
        // needle longer than the haystack
        set_config(64'h6163_6261, 4'd4, 16'd0, 1'b0);
        hay = '{8'h61, 8'h62, 8'h63};
        run_haystack(hay);
    endtask

    task automatic test_forward_search();
        byte_queue_t hay;
        set_config(64'hFFFF_FFFF_FFFF_6261, 4'd2, 16'd0, 1'b0);
        hay = '{8'h78, 8'h61, 8'h62, 8'h61, 8'h62};
        run_haystack(hay);
        set_config(64'h6261, 4'd2, 16'hFFFF, 1'b0);
        hay = '{8'h61, 8'h62};
        run_haystack(hay);
    endtask

    task automatic test_reverse_search();
        byte_queue_t hay;
        set_config(64'h61, 4'd1, 16'hFFFF, 1'b1);
        hay = '{8'h61, 8'h78, 8'h61};
        run_haystack(hay);
        set_config(64'h61, 4'd1, 16'd0, 1'b1);
        hay = '{8'h61};
        run_haystack(hay);
    endtask

    task automatic test_byte_extremes();
        byte_queue_t hay;
        set_config('1, 4'd8, 16'd0, 1'b0);
        hay = '{8{8'hFF}};
        run_haystack(hay);
        set_config(64'd0, 4'd1, 16'd0, 1'b0);
        hay = '{8'h00};
        run_haystack(hay);
    endtask

    task automatic test_random_search(input int item_goal);
        byte_queue_t hay;
        logic [63:0] needle;
        int          len;
        int          hlen;
        int          plant_at;
        int          sent;
        sent = 0;
        while (sent < item_goal)
        begin
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = $urandom_range(9, 15);
                default: len = $urandom_range(1, 8);
            endcase
            // unused needle bytes stay random, they must be ignored
            needle = {$urandom, $urandom};
            for (int i = 0; i < len && i < 8; i++)
                needle[8*i +: 8] = hay_symbol();
            case ($urandom_range(0, 5))
                0: set_config(needle, 4'(len), 16'd0, 1'($urandom));
                1: set_config(needle, 4'(len), 16'hFFFF, 1'($urandom));
                default: set_config(needle, 4'(len), 16'($urandom_range(0, 20)),
                                    1'($urandom));
            endcase
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            repeat ($urandom_range(2, 6))
            begin
                hlen = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 16);
                hay.delete();
                repeat (hlen) hay.push_back(hay_symbol());
                if (len >= 1 && len <= 8 && len <= hlen)
                    repeat ($urandom_range(0, 2))
                    begin
                        plant_at = $urandom_range(0, hlen - len);
                        for (int i = 0; i < len; i++)
                            hay[plant_at + i] = needle[8*i +: 8];
                    end
                run_haystack(hay);
                sent += hlen;
            end
        end
    endtask

    // long receiver stall with short haystacks queued behind it
    task automatic test_result_backpressure();
        byte_queue_t hay;
        set_config(64'h61, 4'd1, 16'd0, 1'b0);
        ready_mode = READY_ALWAYS;
        gaps_on = 1'b0;
        hold_request = 300;
        repeat (40)
        begin
            hay.delete();
            repeat ($urandom_range(1, 3)) hay.push_back(hay_symbol());
            run_haystack(hay);
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge clk)
    begin : result_check
        search_result_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing expected: position %0d found %0b",
                         $time, m_tdata, m_tuser[0]);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== TDATA_W'(want.position))
                begin
                    $display("%0t: match_position expected %0d got %0d",
                             $time, want.position, m_tdata);
                    fail_count++;
                end
                if (m_tuser[0] !== want.found)
                begin
                    $display("%0t: found expected %0b got %0b",
                             $time, want.found, m_tuser[0]);
                    fail_count++;
                end
                if (m_tuser[1] !== want.overflow)
                begin
                    $display("%0t: overflow expected %0b got %0b",
                             $time, want.overflow, m_tuser[1]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else
            begin
                case (ready_mode)
                    READY_COIN:   m_tready = 1'($urandom);
                    READY_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
                    default:      m_tready = 1'b1;
                endcase
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        cfg_needle = '0;
        cfg_len = '0;
        cfg_offset = '0;
        cfg_reverse = 1'b0;
        stream_window = '0;
        bytes_seen = '0;
        match_held = 1'b0;
        match_start = '0;
        fail_count = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        hold_request = 0;
        ready_mode = READY_ALWAYS;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_and_oversized_needle();
        test_forward_search();
        test_reverse_search();
        test_byte_extremes();
        test_random_search(950);
        test_result_backpressure();
        wait_drained();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
